// ===== hw/rtl/mclc_pkg.sv =====
// ----------------------------------------------------------------------------
// mclc_pkg
// Types, constants and helper functions shared by the mip chain layout blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package mclc_pkg;

    localparam int DIM_W    = 15;
    localparam int BLK_W    = 5;
    localparam int BYTES_W  = 7;
    localparam int LVL_W    = 5;
    localparam int FACES_W  = 3;
    localparam int LAYERS_W = 12;
    localparam int ROW_W    = 21;
    localparam int SLICE_W  = 35;
    localparam int SUM_W    = 63;

    localparam int MUL_A_W  = 64;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int RCP_W    = 22;
    localparam int RCP_SH   = 21;
    localparam int MAX_RES  = 16;

    localparam logic [SUM_W-1:0] SAT63 = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV0,
        S_DIV1,
        S_DIV2,
        S_ROW,
        S_SLICE,
        S_VOL,
        S_FACE,
        S_LAYER,
        S_TOTAL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0]    base_width;
        logic [DIM_W-1:0]    base_height;
        logic [DIM_W-1:0]    base_depth;
        logic [BLK_W-1:0]    block_width;
        logic [BLK_W-1:0]    block_height;
        logic [BLK_W-1:0]    block_depth;
        logic [BYTES_W-1:0]  block_bytes;
        logic [LVL_W-1:0]    level_count;
        logic [FACES_W-1:0]  face_count;
        logic [LAYERS_W-1:0] layer_count;
    } t_req;

    typedef struct packed {
        logic [DIM_W-1:0]   level_width;
        logic [DIM_W-1:0]   level_height;
        logic [DIM_W-1:0]   level_depth;
        logic [DIM_W-1:0]   blocks_across;
        logic [DIM_W-1:0]   blocks_down;
        logic [DIM_W-1:0]   blocks_deep;
        logic [ROW_W-1:0]   row_bytes;
        logic [SLICE_W-1:0] slice_bytes;
        logic [SUM_W-1:0]   face_bytes;
        logic [SUM_W-1:0]   layer_bytes;
        logic [SUM_W-1:0]   total_bytes;
        logic               last;
    } t_res;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_op;

    // ceil(2^21 / d); exact floor division for numerators below 2^16
    function automatic logic [RCP_W-1:0] recip(input logic [BLK_W-1:0] d);
        logic [RCP_W-1:0] m;
        case (d)
            5'd2:    m = 22'd1048576;
            5'd3:    m = 22'd699051;
            5'd4:    m = 22'd524288;
            5'd5:    m = 22'd419431;
            5'd6:    m = 22'd349526;
            5'd7:    m = 22'd299594;
            5'd8:    m = 22'd262144;
            5'd9:    m = 22'd233017;
            5'd10:   m = 22'd209716;
            5'd11:   m = 22'd190651;
            5'd12:   m = 22'd174763;
            5'd13:   m = 22'd161320;
            5'd14:   m = 22'd149797;
            5'd15:   m = 22'd139811;
            5'd16:   m = 22'd131072;
            5'd17:   m = 22'd123362;
            5'd18:   m = 22'd116509;
            5'd19:   m = 22'd110377;
            5'd20:   m = 22'd104858;
            5'd21:   m = 22'd99865;
            5'd22:   m = 22'd95326;
            5'd23:   m = 22'd91181;
            5'd24:   m = 22'd87382;
            5'd25:   m = 22'd83887;
            5'd26:   m = 22'd80660;
            5'd27:   m = 22'd77673;
            5'd28:   m = 22'd74899;
            5'd29:   m = 22'd72316;
            5'd30:   m = 22'd69906;
            5'd31:   m = 22'd67651;
            default: m = 22'd2097152;
        endcase
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] sat21(input logic [PROD_W-1:0] p);
        return (p[PROD_W-1:ROW_W] != '0) ? '1 : p[ROW_W-1:0];
    endfunction

    function automatic logic [SLICE_W-1:0] sat35(input logic [PROD_W-1:0] p);
        return (p[PROD_W-1:SLICE_W] != '0) ? '1 : p[SLICE_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat63(input logic [PROD_W-1:0] p);
        return (p[PROD_W-1:SUM_W] != '0) ? SAT63 : p[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mclc_mul.sv =====
// ----------------------------------------------------------------------------
// mclc_mul
// Shared 64x16 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mclc_mul (
    input  wire                                i_clk,
    input  wire  mclc_pkg::t_mul_op            i_op,
    output logic [mclc_pkg::PROD_W-1:0]        o_prod
);
    import mclc_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_prod <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hw/rtl/mclc_seq.sv =====
// ----------------------------------------------------------------------------
// mclc_seq
// Level sequencer: walks the mip chain, drives the shared multiplier and
// builds one result per level.
// ----------------------------------------------------------------------------
`default_nettype none

module mclc_seq #(
    parameter int LEVELS_MAX = 16,
    parameter int MAX_DIM    = 16384
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    input  wire  mclc_pkg::t_req         i_req,
    output logic                         o_req_ready,
    input  wire  [mclc_pkg::PROD_W-1:0]  i_prod,
    output mclc_pkg::t_mul_op            o_mul_op,
    output logic                         o_res_valid,
    output mclc_pkg::t_res               o_res,
    input  wire                          i_out_free
);
    import mclc_pkg::*;

    localparam int DIM_CAP = (MAX_DIM > 32767) ? 32767 : MAX_DIM;
    localparam int LVL_CAP = (LEVELS_MAX < MAX_RES) ? LEVELS_MAX : MAX_RES;

    t_state r_state, n_state;

    logic [DIM_W-1:0]    r_dim [3];
    logic [BLK_W-1:0]    r_blk [3];
    logic [DIM_W-1:0]    r_nb  [3];
    logic [BYTES_W-1:0]  r_bytes;
    logic [LVL_W-1:0]    r_levels;
    logic [LVL_W-1:0]    r_count;
    logic [FACES_W-1:0]  r_faces;
    logic [LAYERS_W-1:0] r_layers;
    logic [ROW_W-1:0]    r_row;
    logic [SLICE_W-1:0]  r_slice;
    logic [SUM_W-1:0]    r_face;
    logic [SUM_W-1:0]    r_layer;

    logic [DIM_W-1:0]    w_dim_in [3];
    logic [BLK_W-1:0]    w_blk_in [3];
    logic [DIM_W-1:0]    w_dim_raw [3];
    logic [BLK_W-1:0]    w_blk_raw [3];
    logic [LVL_W-1:0]    w_lvl_in;
    logic                w_ok;
    logic                w_unit;
    logic                w_last;
    logic [MUL_A_W-1:0]  w_face_sum;
    logic [LVL_W-1:0]    w_count_inc;

    assign w_dim_raw[0] = i_req.base_width;
    assign w_dim_raw[1] = i_req.base_height;
    assign w_dim_raw[2] = i_req.base_depth;
    assign w_blk_raw[0] = i_req.block_width;
    assign w_blk_raw[1] = i_req.block_height;
    assign w_blk_raw[2] = i_req.block_depth;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dim_in[i] = ({2'b0, w_dim_raw[i]} > 17'(DIM_CAP)) ? DIM_W'(DIM_CAP)
                                                                  : w_dim_raw[i];
            w_blk_in[i] = (w_blk_raw[i] == '0) ? BLK_W'(1) : w_blk_raw[i];
        end
        w_lvl_in = (i_req.level_count > LVL_W'(LVL_CAP)) ? LVL_W'(LVL_CAP)
                                                         : i_req.level_count;
        w_ok = (w_dim_in[0] != '0) && (w_dim_in[1] != '0) && (w_dim_in[2] != '0)
               && (i_req.level_count != '0);
    end

    function automatic logic [MUL_B_W-1:0] numer(input logic [DIM_W-1:0] d,
                                                 input logic [BLK_W-1:0] b);
        return MUL_B_W'(d) + MUL_B_W'(b) - MUL_B_W'(1);
    endfunction

    assign w_unit      = (r_dim[0] == DIM_W'(1)) && (r_dim[1] == DIM_W'(1))
                         && (r_dim[2] == DIM_W'(1));
    assign w_count_inc = r_count + LVL_W'(1);
    assign w_last      = w_unit || (w_count_inc == r_levels);
    assign w_face_sum  = {1'b0, r_face} + MUL_A_W'(i_prod[MUL_A_W-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req_valid && w_ok) n_state = S_DIV0;
            S_DIV0:  n_state = S_DIV1;
            S_DIV1:  n_state = S_DIV2;
            S_DIV2:  n_state = S_ROW;
            S_ROW:   n_state = S_SLICE;
            S_SLICE: n_state = S_VOL;
            S_VOL:   n_state = S_FACE;
            S_FACE:  n_state = S_LAYER;
            S_LAYER: n_state = S_TOTAL;
            S_TOTAL: n_state = S_EMIT;
            S_EMIT:  begin
                if (i_out_free) n_state = w_last ? S_IDLE : S_DIV0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_mul_op    = '0;
        case (r_state)
            S_IDLE:  o_req_ready = 1'b1;
            S_DIV0:  begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(recip(r_blk[0]));
                o_mul_op.b  = numer(r_dim[0], r_blk[0]);
            end
            S_DIV1:  begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(recip(r_blk[1]));
                o_mul_op.b  = numer(r_dim[1], r_blk[1]);
            end
            S_DIV2:  begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(recip(r_blk[2]));
                o_mul_op.b  = numer(r_dim[2], r_blk[2]);
            end
            S_ROW:   begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(r_bytes);
                o_mul_op.b  = MUL_B_W'(r_nb[0]);
            end
            S_SLICE: begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(sat21(i_prod));
                o_mul_op.b  = MUL_B_W'(r_nb[1]);
            end
            S_VOL:   begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(sat35(i_prod));
                o_mul_op.b  = MUL_B_W'(r_nb[2]);
            end
            S_LAYER: begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(r_face);
                o_mul_op.b  = MUL_B_W'(r_faces);
            end
            S_TOTAL: begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = MUL_A_W'(sat63(i_prod));
                o_mul_op.b  = MUL_B_W'(r_layers);
            end
            S_EMIT:  o_res_valid = 1'b1;
            default: o_req_ready = 1'b0;
        endcase
    end

    always_comb begin
        o_res.level_width   = r_dim[0];
        o_res.level_height  = r_dim[1];
        o_res.level_depth   = r_dim[2];
        o_res.blocks_across = r_nb[0];
        o_res.blocks_down   = r_nb[1];
        o_res.blocks_deep   = r_nb[2];
        o_res.row_bytes     = r_row;
        o_res.slice_bytes   = r_slice;
        o_res.face_bytes    = r_face;
        o_res.layer_bytes   = r_layer;
        o_res.total_bytes   = sat63(i_prod);
        o_res.last          = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE:  begin
                if (i_req_valid) begin
                    for (int i = 0; i < 3; i++) begin
                        r_dim[i] <= w_dim_in[i];
                        r_blk[i] <= w_blk_in[i];
                    end
                    r_bytes  <= i_req.block_bytes;
                    r_levels <= w_lvl_in;
                    r_faces  <= i_req.face_count;
                    r_layers <= i_req.layer_count;
                    r_count  <= '0;
                    r_face   <= '0;
                end
            end
            S_DIV1:  r_nb[0] <= i_prod[RCP_SH+DIM_W-1:RCP_SH];
            S_DIV2:  r_nb[1] <= i_prod[RCP_SH+DIM_W-1:RCP_SH];
            S_ROW:   r_nb[2] <= i_prod[RCP_SH+DIM_W-1:RCP_SH];
            S_SLICE: r_row   <= sat21(i_prod);
            S_VOL:   r_slice <= sat35(i_prod);
            S_FACE:  r_face  <= w_face_sum[SUM_W] ? SAT63 : w_face_sum[SUM_W-1:0];
            S_TOTAL: r_layer <= sat63(i_prod);
            S_EMIT:  begin
                if (i_out_free && !w_last) begin
                    for (int i = 0; i < 3; i++) begin
                        r_dim[i] <= (r_dim[i] > DIM_W'(1)) ? (r_dim[i] >> 1) : DIM_W'(1);
                    end
                    r_count <= w_count_inc;
                end
            end
            default: r_count <= r_count;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mip_chain_layout_calculator.sv =====
// ----------------------------------------------------------------------------
// mip_chain_layout_calculator
// Walks a texture mip chain and streams out per-level block counts, spans and
// saturating face, layer and total sizes.
// ----------------------------------------------------------------------------
// All levels are computed on one shared 64x16 multiplier (3 divides by reciprocal,
//   5 products per level).
// Input ready only when idle: a new request is taken only after the previous chain is done.
// Requests with a zero dimension or zero level count give no output.
// Reset: synchronous, active low; clears sequencer state and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_chain_layout_calculator #(
    parameter int LEVELS_MAX = 16,
    parameter int MAX_DIM    = 16384
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // base_width, base_height, base_depth, block_width, block_height,
    // block_depth, block_bytes, level_count, face_count, layer_count, pad
    input  wire  [87:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // level_width, level_height, level_depth, blocks_across, blocks_down,
    // blocks_deep, row_bytes, slice_bytes, face_bytes, layer_bytes,
    // total_bytes, pad
    output logic [335:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast
);
    import mclc_pkg::*;

    t_req              w_req;
    t_res              w_res;
    t_mul_op           w_mul_op;
    logic [PROD_W-1:0] w_prod;
    logic              w_res_valid;
    logic              w_out_free;

    logic              r_out_valid;
    logic [335:0]      r_out_data;
    logic              r_out_last;

    assign w_req.base_width   = i_s_axis_tdata[14:0];
    assign w_req.base_height  = i_s_axis_tdata[29:15];
    assign w_req.base_depth   = i_s_axis_tdata[44:30];
    assign w_req.block_width  = i_s_axis_tdata[49:45];
    assign w_req.block_height = i_s_axis_tdata[54:50];
    assign w_req.block_depth  = i_s_axis_tdata[59:55];
    assign w_req.block_bytes  = i_s_axis_tdata[66:60];
    assign w_req.level_count  = i_s_axis_tdata[71:67];
    assign w_req.face_count   = i_s_axis_tdata[74:72];
    assign w_req.layer_count  = i_s_axis_tdata[86:75];

    mclc_seq #(
        .LEVELS_MAX (LEVELS_MAX),
        .MAX_DIM    (MAX_DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req       (w_req),
        .o_req_ready (o_s_axis_tready),
        .i_prod      (w_prod),
        .o_mul_op    (w_mul_op),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_out_free  (w_out_free)
    );

    mclc_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (w_mul_op),
        .o_prod (w_prod)
    );

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out_data <= {1'b0, w_res.total_bytes, w_res.layer_bytes, w_res.face_bytes,
                           w_res.slice_bytes, w_res.row_bytes, w_res.blocks_deep,
                           w_res.blocks_down, w_res.blocks_across, w_res.level_depth,
                           w_res.level_height, w_res.level_width};
            r_out_last <= w_res.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata[14:0] != '0)
         && (i_s_axis_tdata[29:15] != '0) && (i_s_axis_tdata[44:30] != '0)
         && (i_s_axis_tdata[71:67] != '0)) |=> !o_s_axis_tready)
        else $error("request accepted but sequencer still ready");

    a_dims_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:0] != '0) && (o_m_axis_tdata[29:15] != '0)
                            && (o_m_axis_tdata[44:30] != '0))
        else $error("zero level dimension on output");

    a_blocks_le_texels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[59:45] <= o_m_axis_tdata[14:0])
                            && (o_m_axis_tdata[74:60] <= o_m_axis_tdata[29:15]))
        else $error("block count exceeds texel count");

    a_no_emit_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_res_valid)
        else $error("result offered while idle");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mip_chain_layout_calculator. Layout requests go in
// on the slave stream, one transfer per level comes back on the master
// stream. A directed table covers the corner cases, then random requests
// follow. Each level is checked field by field against the table's expected
// values or a local model of the chain walk, with random gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import mclc_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 480;
    localparam int DRAIN_AT      = 240;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;
    localparam int DIM_LIMIT     = 16384;
    localparam int LEVEL_LIMIT   = 16;
    localparam logic [63:0] SPAN_MAX = {1'b0, SAT63};

    typedef enum {ROW_PREDICT, ROW_SILENT, ROW_TYPED} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_req      req;
        t_res      level;
    } t_plan_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [87:0]  s_data = '0;
    logic         m_ready = 1'b0;
    wire          s_ready;
    wire          m_valid;
    wire  [335:0] m_data;
    wire          m_last;

    t_res      pending_levels[$];
    t_plan_row plan[18];
    int        failures = 0;
    int        levels_seen = 0;
    int        cycles = 0;

    mip_chain_layout_calculator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_req mk_req(int w, int h, int d, int bw, int bh, int bd,
                                    int bytes, int lvl, int faces, int layers);
        t_req r;
        r.base_width   = DIM_W'(w);
        r.base_height  = DIM_W'(h);
        r.base_depth   = DIM_W'(d);
        r.block_width  = BLK_W'(bw);
        r.block_height = BLK_W'(bh);
        r.block_depth  = BLK_W'(bd);
        r.block_bytes  = BYTES_W'(bytes);
        r.level_count  = LVL_W'(lvl);
        r.face_count   = FACES_W'(faces);
        r.layer_count  = LAYERS_W'(layers);
        return r;
    endfunction

    // single 1x1x1 level: every count is one, so the spans follow from bytes
    function automatic t_res unit_level(longint unsigned row, longint unsigned face,
                                        longint unsigned layer, longint unsigned total);
        t_res lv;
        lv.level_width   = 1;
        lv.level_height  = 1;
        lv.level_depth   = 1;
        lv.blocks_across = 1;
        lv.blocks_down   = 1;
        lv.blocks_deep   = 1;
        lv.row_bytes     = ROW_W'(row);
        lv.slice_bytes   = SLICE_W'(row);
        lv.face_bytes    = SUM_W'(face);
        lv.layer_bytes   = SUM_W'(layer);
        lv.total_bytes   = SUM_W'(total);
        lv.last          = 1'b1;
        return lv;
    endfunction

    function automatic logic [87:0] pack_request(t_req r);
        return {1'b0, r.layer_count, r.face_count, r.level_count, r.block_bytes,
                r.block_depth, r.block_height, r.block_width,
                r.base_depth, r.base_height, r.base_width};
    endfunction

    function automatic t_res unpack_level(logic [335:0] d, logic l);
        t_res lv;
        lv.level_width   = d[14:0];
        lv.level_height  = d[29:15];
        lv.level_depth   = d[44:30];
        lv.blocks_across = d[59:45];
        lv.blocks_down   = d[74:60];
        lv.blocks_deep   = d[89:75];
        lv.row_bytes     = d[110:90];
        lv.slice_bytes   = d[145:111];
        lv.face_bytes    = d[208:146];
        lv.layer_bytes   = d[271:209];
        lv.total_bytes   = d[334:272];
        lv.last          = l;
        return lv;
    endfunction

    function automatic logic [63:0] clamp_sum(logic [63:0] a, logic [63:0] b);
        return (a > SPAN_MAX - b) ? SPAN_MAX : a + b;
    endfunction

    function automatic logic [63:0] clamp_product(logic [63:0] a, logic [63:0] b);
        if (a == 0 || b == 0)
            return 0;
        return (a > SPAN_MAX / b) ? SPAN_MAX : a * b;
    endfunction

    function automatic logic [63:0] clamp_width(logic [63:0] v, int bits);
        logic [63:0] lim;
        lim = (64'd1 << bits) - 1;
        return (v > lim) ? lim : v;
    endfunction

    // walks the chain and queues one expected level per step
    function automatic int predict_levels(t_req r);
        logic [63:0] dim[3];
        logic [63:0] blk[3];
        logic [63:0] nb[3];
        logic [63:0] row, slice, face, levels;
        logic        unit;
        t_res        lv;
        int          n;
        dim[0] = r.base_width;
        dim[1] = r.base_height;
        dim[2] = r.base_depth;
        blk[0] = r.block_width;
        blk[1] = r.block_height;
        blk[2] = r.block_depth;
        face   = 0;
        n      = 0;
        for (int i = 0; i < 3; i++) begin
            if (dim[i] > DIM_LIMIT)
                dim[i] = DIM_LIMIT;
            if (blk[i] == 0)
                blk[i] = 1;
        end
        if (dim[0] == 0 || dim[1] == 0 || dim[2] == 0)
            return 0;
        levels = r.level_count;
        if (levels > LEVEL_LIMIT)
            levels = LEVEL_LIMIT;
        while (n < levels) begin
            unit = (dim[0] == 1 && dim[1] == 1 && dim[2] == 1);
            for (int i = 0; i < 3; i++)
                nb[i] = (dim[i] + blk[i] - 1) / blk[i];
            row   = clamp_width(nb[0] * r.block_bytes, ROW_W);
            slice = clamp_width(nb[1] * row, SLICE_W);
            face  = clamp_sum(face, clamp_product(slice, nb[2]));
            lv.level_width   = DIM_W'(dim[0]);
            lv.level_height  = DIM_W'(dim[1]);
            lv.level_depth   = DIM_W'(dim[2]);
            lv.blocks_across = DIM_W'(nb[0]);
            lv.blocks_down   = DIM_W'(nb[1]);
            lv.blocks_deep   = DIM_W'(nb[2]);
            lv.row_bytes     = ROW_W'(row);
            lv.slice_bytes   = SLICE_W'(slice);
            lv.face_bytes    = SUM_W'(face);
            lv.layer_bytes   = SUM_W'(clamp_product(face, r.face_count));
            lv.total_bytes   = SUM_W'(clamp_product(clamp_product(face, r.face_count),
                                                    r.layer_count));
            n++;
            lv.last = unit || (n == levels);
            pending_levels.push_back(lv);
            if (unit)
                break;
            for (int i = 0; i < 3; i++)
                dim[i] = (dim[i] > 1) ? dim[i] >> 1 : 64'd1;
        end
        return n;
    endfunction

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        int len;
        len = $urandom_range(0, 14);
        return DIM_W'(1 + $urandom_range(0, (1 << len) - 1));
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int          pick;
        logic [95:0] raw;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            raw = {$urandom, $urandom, $urandom};
            r   = t_req'(raw[86:0]);
        end else begin
            r = mk_req(random_dim(), random_dim(), ($urandom_range(0, 1) ? 1 : random_dim()),
                       $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                       $urandom_range(1, 64), $urandom_range(1, 16),
                       ($urandom_range(0, 2) == 0) ? 6 : $urandom_range(1, 6),
                       $urandom_range(0, 3) ? $urandom_range(1, 16) : $urandom_range(1, 2048));
            if ($urandom_range(0, 1)) begin
                r.block_width  = BLK_W'(1 << $urandom_range(0, 3));
                r.block_height = r.block_width;
                r.block_depth  = 1;
            end
            if (pick == 1) begin
                case ($urandom_range(0, 3))
                    0: r.base_width  = 0;
                    1: r.base_height = 0;
                    2: r.base_depth  = 0;
                    default: r.level_count = 0;
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_request(t_req r, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= pack_request(r);
        do @(posedge i_clk); while (s_ready !== 1'b1);
    endtask

    function automatic void check_field(string name, logic [62:0] want, logic [62:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= REPORT_MAX)
                $display("level %0d %s: expected %0h, got %0h", levels_seen, name, want, got);
        end
    endfunction

    initial begin
        t_res got, want;
        int   stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_wait((levels_seen / 60) % 3 == 1);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (m_valid !== 1'b1);
            got = unpack_level(m_data, m_last);
            if (pending_levels.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected transfer: %0h last %0b", m_data, m_last);
            end else begin
                want = pending_levels.pop_front();
                check_field("level_width",   want.level_width,   got.level_width);
                check_field("level_height",  want.level_height,  got.level_height);
                check_field("level_depth",   want.level_depth,   got.level_depth);
                check_field("blocks_across", want.blocks_across, got.blocks_across);
                check_field("blocks_down",   want.blocks_down,   got.blocks_down);
                check_field("blocks_deep",   want.blocks_deep,   got.blocks_deep);
                check_field("row_bytes",     want.row_bytes,     got.row_bytes);
                check_field("slice_bytes",   want.slice_bytes,   got.slice_bytes);
                check_field("face_bytes",    want.face_bytes,    got.face_bytes);
                check_field("layer_bytes",   want.layer_bytes,   got.layer_bytes);
                check_field("total_bytes",   want.total_bytes,   got.total_bytes);
                check_field("last",          want.last,          got.last);
            end
            levels_seen++;
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_req r;
        int   produced;
        int   sent;
        plan[0]  = '{ROW_TYPED,   mk_req(1, 1, 1, 1, 1, 1, 1, 1, 1, 1), unit_level(1, 1, 1, 1)};
        plan[1]  = '{ROW_SILENT,  mk_req(0, 8, 8, 1, 1, 1, 4, 4, 1, 1), '0};
        plan[2]  = '{ROW_SILENT,  mk_req(8, 0, 8, 1, 1, 1, 4, 4, 1, 1), '0};
        plan[3]  = '{ROW_SILENT,  mk_req(8, 8, 0, 1, 1, 1, 4, 4, 1, 1), '0};
        plan[4]  = '{ROW_SILENT,  mk_req(8, 8, 8, 1, 1, 1, 4, 0, 1, 1), '0};
        plan[5]  = '{ROW_TYPED,   mk_req(1, 1, 1, 1, 1, 1, 4, 31, 6, 2), unit_level(4, 4, 24, 48)};
        plan[6]  = '{ROW_TYPED,   mk_req(1, 1, 1, 1, 1, 1, 0, 5, 3, 3), unit_level(0, 0, 0, 0)};
        plan[7]  = '{ROW_TYPED,   mk_req(1, 1, 1, 16, 16, 16, 64, 16, 1, 2048),
                     unit_level(64, 64, 64, 131072)};
        plan[8]  = '{ROW_PREDICT, mk_req(16384, 16384, 16384, 1, 1, 1, 64, 16, 6, 2048), '0};
        plan[9]  = '{ROW_PREDICT, mk_req(32767, 32767, 32767, 31, 31, 31, 127, 31, 7, 4095),
                     '0};
        plan[10] = '{ROW_PREDICT, mk_req(32767, 32767, 32767, 1, 1, 1, 127, 31, 7, 4095), '0};
        plan[11] = '{ROW_PREDICT, mk_req(100, 60, 20, 0, 0, 0, 3, 16, 1, 1), '0};
        plan[12] = '{ROW_PREDICT, mk_req(64, 64, 64, 4, 4, 4, 16, 8, 0, 5), '0};
        plan[13] = '{ROW_PREDICT, mk_req(256, 256, 1, 4, 4, 1, 8, 9, 6, 0), '0};
        plan[14] = '{ROW_PREDICT, mk_req(17, 33, 5, 16, 16, 16, 64, 16, 6, 7), '0};
        plan[15] = '{ROW_PREDICT, mk_req(1000, 3, 1, 5, 3, 1, 10, 16, 1, 1), '0};
        plan[16] = '{ROW_PREDICT, mk_req(4096, 4096, 1, 4, 4, 1, 16, 13, 6, 2048), '0};
        plan[17] = '{ROW_PREDICT, mk_req(16384, 2, 16384, 8, 1, 8, 32, 20, 2, 3), '0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            send_request(plan[i].req, draw_wait(1'b0));
            case (plan[i].kind)
                ROW_TYPED:   pending_levels.push_back(plan[i].level);
                ROW_PREDICT: produced = predict_levels(plan[i].req);
                default: ;
            endcase
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = random_request();
            send_request(r, draw_wait(sent >= 100 && sent < 160));
            produced = predict_levels(r);
            if (produced > 0)
                sent++;
            if (sent == DRAIN_AT && produced > 0) begin
                s_valid <= 1'b0;
                while (pending_levels.size() != 0) @(posedge i_clk);
            end
        end
        s_valid <= 1'b0;

        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
